@@ sv/mwtd_pkg.sv @@
// Package for the Mobius wheel trial division block.
// Holds the wheel step table, state codes and controller/datapath bundles.
// No dependencies.
package mwtd_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] MU_ZERO = 2'b00;
    localparam logic [1:0] MU_POS  = 2'b01;
    localparam logic [1:0] MU_NEG  = 2'b11;

    // One-hot controller states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_EVAL  = 6'b001000,
        S_SQ    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture input, reset divisor sequence
        logic div_start; // start m / d
        logic take_quo;  // replace m by quotient, flip sign
        logic next_d;    // advance divisor along the schedule
        logic sq_start;  // start d*d compare
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic trivial;   // value below 2: answer known at once
        logic div_done;
        logic rem_zero;
        logic sq_done;
        logic sq_le;     // d*d <= m
        logic tail;      // divisor schedule 2,3,5 finished, wheel active
    } t_stat;

    // mod-30 wheel increments, starting from 7.
    function automatic logic [2:0] wheel_step(input logic [2:0] k);
        unique case (k)
            3'd0: wheel_step = 3'd4;
            3'd1: wheel_step = 3'd2;
            3'd2: wheel_step = 3'd4;
            3'd3: wheel_step = 3'd2;
            3'd4: wheel_step = 3'd4;
            3'd5: wheel_step = 3'd6;
            3'd6: wheel_step = 3'd2;
            default: wheel_step = 3'd6;
        endcase
    endfunction

endpackage

@@ sv/mobius_wheel_trial_division.sv @@
// Top level of the Mobius wheel trial division block.
// Depends on mwtd_pkg, mwtd_ctrl and mwtd_dp.
//
//  Channel | Ports                | Transfer when
//  --------+----------------------+-------------------------------
//  input   | i_start, i_value     | i_start high and o_busy low
//  result  | o_valid, o_mu        | o_valid high (one cycle only)
//
// Values below 2 go from S_CHECK straight to S_DONE, which strobes o_valid.
// Otherwise each trial divisor costs one restoring division plus, on the wheel,
// a shift-add squaring; one divider serves every divisor up to sqrt(value).
// Reset clears the controller; the datapath holds no reset state.
// The receiver cannot stall: o_valid is a single-cycle strobe.
module mobius_wheel_trial_division #(
    parameter int unsigned VALUE_WIDTH = mwtd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic signed [1:0]             o_mu
);
    import mwtd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  zero;

    // Controller: sequence divisor trials, track repeated hits.
    mwtd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_valid),
        .o_zero  (zero)
    );

    // Datapath: hold remaining value, divisor, divider and squarer.
    mwtd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (cmd),
        .i_zero  (zero),
        .o_stat  (stat),
        .o_mu    (o_mu)
    );
endmodule

@@ sv/mwtd_ctrl.sv @@
// Controller state machine for the Mobius wheel trial division block.
// Depends on mwtd_pkg.
module mwtd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mwtd_pkg::t_stat i_stat,
    output mwtd_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output logic            o_zero
);
    import mwtd_pkg::*;

    t_state r_state, n_state;
    logic   r_hit, n_hit;   // current divisor divided once already
    logic   r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        n_zero  = r_zero;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_hit      = 1'b0;
                    n_zero     = 1'b0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.trivial) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.rem_zero && r_hit) begin
                    // square factor
                    n_zero  = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.rem_zero) begin
                    o_cmd.take_quo  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_hit           = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.next_d = 1'b1;
                    n_hit        = 1'b0;
                    n_state      = S_SQ;
                end
            end
            S_SQ: begin
                // 2,3,5 always tried; wheel divisors only while d*d <= m
                if (!i_stat.tail) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (!i_stat.sq_done) begin
                    o_cmd.sq_start = 1'b1;
                end else if (i_stat.sq_le) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_zero = r_zero;
endmodule

@@ sv/mwtd_dp.sv @@
// Datapath for the Mobius wheel trial division block: remaining value, divisor,
// radix-2 restoring divider, serial squarer and sign. Depends on mwtd_pkg.
module mwtd_dp #(
    parameter int unsigned VALUE_WIDTH = mwtd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  mwtd_pkg::t_cmd                i_cmd,
    input  logic                          i_zero,
    output mwtd_pkg::t_stat               o_stat,
    output logic signed [1:0]             o_mu
);
    import mwtd_pkg::*;

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned DW = (W + 1) / 2 + 1;   // divisor never exceeds sqrt range
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned SW = 2 * DW;

    logic [W-1:0]  r_m;
    logic [DW-1:0] r_d;
    logic [2:0]    r_k;
    logic [1:0]    r_phase;   // 0:2 1:3 2:5 3:wheel
    logic          r_neg;
    logic          r_trivial;
    logic          r_pos_one;

    // divider
    logic [W-1:0]  r_quo, r_rem;
    logic [CW-1:0] r_dcnt;
    logic          r_dbusy, r_ddone;
    logic [W:0]    trial;

    // squarer: shift-add
    logic [SW-1:0] r_acc, r_mcand;
    logic [DW-1:0] r_mplier;
    logic          r_sbusy, r_sdone;

    logic [W-1:0] dext;
    assign dext  = W'(r_d);
    assign trial = {r_rem, r_quo[W-1]} - {1'b0, dext};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m       <= i_value;
            r_d       <= DW'(2);
            r_k       <= '0;
            r_phase   <= '0;
            r_neg     <= 1'b0;
            r_trivial <= i_value[W-1] || (i_value[W-1:1] == '0);
            r_pos_one <= (i_value == W'(1));
        end else begin
            if (i_cmd.take_quo) begin
                r_m   <= r_quo;
                r_neg <= !r_neg;
            end
            if (i_cmd.next_d) begin
                unique case (r_phase)
                    2'd0: r_d <= DW'(3);
                    2'd1: r_d <= DW'(5);
                    2'd2: r_d <= DW'(7);
                    default: begin
                        r_d <= r_d + DW'(wheel_step(r_k));
                        r_k <= r_k + 3'd1;
                    end
                endcase
                if (r_phase != 2'd3) begin
                    r_phase <= r_phase + 2'd1;
                end
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        r_ddone <= 1'b0;
        if (i_cmd.load) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_quo   <= i_cmd.take_quo ? r_quo : r_m;
            r_rem   <= '0;
            r_dcnt  <= CW'(W);
            r_dbusy <= 1'b1;
        end else if (r_dbusy) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - CW'(1);
            if (r_dcnt == CW'(1)) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
    end

    // Serial squarer for the d*d <= m loop test.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.next_d) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else if (i_cmd.sq_start && !r_sbusy) begin
            r_acc    <= '0;
            r_mcand  <= SW'(r_d);
            r_mplier <= r_d;
            r_sbusy  <= 1'b1;
        end else if (r_sbusy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            if (r_mplier[DW-1:1] == '0) begin
                r_sbusy <= 1'b0;
                r_sdone <= 1'b1;
            end
        end
    end

    // The retake of the quotient after a hit divides the new m: r_quo holds it.
    always_comb begin
        o_stat          = '0;
        o_stat.trivial  = r_trivial;
        o_stat.div_done = r_ddone;
        o_stat.rem_zero = (r_rem == '0);
        o_stat.sq_done  = r_sdone;
        o_stat.sq_le    = ((r_acc + SW'(r_mplier[0] ? r_mcand : '0)) <= SW'(r_m))
                          && !r_sbusy;
        o_stat.tail     = (r_phase == 2'd3);
    end

    always_comb begin
        priority if (r_trivial) begin
            o_mu = r_pos_one ? MU_POS : MU_ZERO;
        end else if (i_zero) begin
            o_mu = MU_ZERO;
        end else begin
            // leftover m above 1 flips once more
            o_mu = ((r_m != W'(1)) ^ r_neg) ? MU_NEG : MU_POS;
        end
    end
endmodule
